@@ rtl/assert_macros.svh @@
// Assertion helpers, sampled on clk_i and switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge.
`define PIMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PIMC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define PIMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/pimc_pkg.sv @@
package pimc_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CLK_W      = 27;
  localparam int PER_W      = 16;
  localparam int FREQ_W     = 26;
  localparam int DUTY_W     = 15;
  localparam int SCALE_W    = 15;
  localparam int DIV_BITS   = (COUNT_BITS + SCALE_W > CLK_W) ? COUNT_BITS + SCALE_W : CLK_W;
  localparam int STEP_W     = $clog2(DIV_BITS);
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int OUT_DATA_W = 64;

  localparam logic [CLK_W-1:0]   CLOCK_RESET = CLK_W'(8000000);
  localparam logic [SCALE_W-1:0] DUTY_SCALE  = SCALE_W'(25600);
  localparam logic [FREQ_W-1:0]  FREQ_MAX    = {FREQ_W{1'b1}};

  typedef struct packed {
    logic [COUNT_BITS-1:0] rise1;
    logic [COUNT_BITS-1:0] fall;
    logic [COUNT_BITS-1:0] rise2;
  } capt_t;

endpackage

@@ rtl/pimc_front.sv @@
module pimc_front
  import pimc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  func_i,
  input  logic  level_i,
  output logic  push_o,
  output capt_t capt_o,
  input  logic  full_i
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_WAIT_R1 = 4'b0010,
    ST_WAIT_F  = 4'b0100,
    ST_WAIT_R2 = 4'b1000
  } stage_e;

  stage_e                stage_q, stage_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                  prev_q, prev_d;
  logic [COUNT_BITS-1:0] rise1_q, rise1_d;
  logic [COUNT_BITS-1:0] fall_q, fall_d;
  logic                  accept, rise, fall;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign rise       = !prev_q && level_i;
  assign fall       = prev_q && !level_i;

  assign capt_o.rise1 = rise1_q;
  assign capt_o.fall  = fall_q;
  assign capt_o.rise2 = cnt_q;

  always_comb begin
    stage_d = stage_q;
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    rise1_d = rise1_q;
    fall_d  = fall_q;
    push_o  = 1'b0;
    if (accept) begin
      if (func_i) begin
        cnt_d   = '0;
        stage_d = ST_WAIT_R1;
      end else begin
        prev_d = level_i;
        unique case (stage_q)
          ST_IDLE: begin
          end
          ST_WAIT_R1: begin
            if (rise) begin
              rise1_d = cnt_q;
              stage_d = ST_WAIT_F;
            end
          end
          ST_WAIT_F: begin
            if (fall) begin
              fall_d  = cnt_q;
              stage_d = ST_WAIT_R2;
            end
          end
          ST_WAIT_R2: begin
            if (rise) begin
              push_o  = 1'b1;
              stage_d = ST_IDLE;
            end
          end
          default: stage_d = ST_IDLE;
        endcase
        if (stage_d != ST_IDLE) begin
          cnt_d = cnt_q + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_IDLE;
      cnt_q   <= '0;
      prev_q  <= 1'b1;
    end else begin
      stage_q <= stage_d;
      cnt_q   <= cnt_d;
      prev_q  <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rise1_q <= rise1_d;
    fall_q  <= fall_d;
  end

  `PIMC_ASSERT_NEXT(a_front_push_idle, push_o, stage_q == ST_IDLE, "capture did not stop")
  `PIMC_ASSERT_IMP(a_front_push_room, push_o, !full_i, "capture pushed into full queue")
  `PIMC_ASSERT_NEXT(a_front_idle_hold, stage_q == ST_IDLE && !(accept && func_i),
                    $stable(cnt_q), "counter ran while idle")

endmodule

@@ rtl/pimc_fifo.sv @@
module pimc_fifo
  import pimc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  capt_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output capt_t rdata_o,
  output logic  empty_o
);

  `include "assert_macros.svh"

  capt_t                   mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wptr_q, rptr_q;
  logic [FIFO_AW:0]        cnt_q;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wptr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rptr_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `PIMC_ASSERT(a_fifo_bound, cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH), "queue count overrun")
  `PIMC_ASSERT_IMP(a_fifo_pop_nonempty, pop_i, !empty_o, "pop from empty queue")

endmodule

@@ rtl/pimc_back.sv @@
module pimc_back
  import pimc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CLK_W-1:0]      cfg_data_i,
  input  logic                  empty_i,
  input  capt_t                 capt_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  valid_res_o,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    BK_IDLE = 4'b0001,
    BK_LOAD = 4'b0010,
    BK_DIV  = 4'b0100,
    BK_OUT  = 4'b1000
  } back_e;

  back_e                 state_q, state_d;
  logic [CLK_W-1:0]      clk_hz_q;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  ok_q;
  logic [COUNT_BITS-1:0] per_q, high_q;
  logic [DIV_BITS-1:0]   f_quo_q, f_quo_d, d_quo_q, d_quo_d;
  logic [COUNT_BITS-1:0] f_rem_q, f_rem_d, d_rem_q, d_rem_d;
  logic [COUNT_BITS:0]   f_cat, f_trial, d_cat, d_trial;
  logic [FREQ_W-1:0]     freq;
  logic                  ok_in;

  assign cfg_ready_o = 1'b1;
  assign pop_o       = (state_q == BK_IDLE) && !empty_i;
  assign out_valid_o = (state_q == BK_OUT);
  assign ok_in       = (capt_i.rise1 < capt_i.fall) && (capt_i.fall < capt_i.rise2);

  assign f_cat   = {f_rem_q, f_quo_q[DIV_BITS-1]};
  assign f_trial = f_cat - {1'b0, per_q};
  assign d_cat   = {d_rem_q, d_quo_q[DIV_BITS-1]};
  assign d_trial = d_cat - {1'b0, per_q};

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    f_quo_d = f_quo_q;
    f_rem_d = f_rem_q;
    d_quo_d = d_quo_q;
    d_rem_d = d_rem_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          state_d = BK_LOAD;
        end
      end
      BK_LOAD: begin
        f_quo_d = DIV_BITS'(clk_hz_q);
        d_quo_d = DIV_BITS'({{(DIV_BITS-COUNT_BITS){1'b0}}, high_q} * DIV_BITS'(DUTY_SCALE));
        f_rem_d = '0;
        d_rem_d = '0;
        step_d  = STEP_W'(DIV_BITS-1);
        state_d = BK_DIV;
      end
      BK_DIV: begin
        if (!f_trial[COUNT_BITS]) begin
          f_rem_d = f_trial[COUNT_BITS-1:0];
          f_quo_d = {f_quo_q[DIV_BITS-2:0], 1'b1};
        end else begin
          f_rem_d = f_cat[COUNT_BITS-1:0];
          f_quo_d = {f_quo_q[DIV_BITS-2:0], 1'b0};
        end
        if (!d_trial[COUNT_BITS]) begin
          d_rem_d = d_trial[COUNT_BITS-1:0];
          d_quo_d = {d_quo_q[DIV_BITS-2:0], 1'b1};
        end else begin
          d_rem_d = d_cat[COUNT_BITS-1:0];
          d_quo_d = {d_quo_q[DIV_BITS-2:0], 1'b0};
        end
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (out_ready_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      step_q   <= '0;
      clk_hz_q <= CLOCK_RESET;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (cfg_valid_i) begin
        clk_hz_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f_quo_q <= f_quo_d;
    f_rem_q <= f_rem_d;
    d_quo_q <= d_quo_d;
    d_rem_q <= d_rem_d;
    if (pop_o) begin
      ok_q   <= ok_in;
      per_q  <= capt_i.rise2 - capt_i.rise1;
      high_q <= capt_i.fall - capt_i.rise1;
    end
  end

  assign freq = (f_quo_q > DIV_BITS'(FREQ_MAX)) ? FREQ_MAX : f_quo_q[FREQ_W-1:0];

  assign valid_res_o = ok_q;
  assign out_data_o  = ok_q ?
      OUT_DATA_W'({d_quo_q[DUTY_W-1:0], freq, PER_W'(per_q)}) : '0;

  `PIMC_ASSERT_NEXT(a_back_load, state_q == BK_LOAD,
                    state_q == BK_DIV && step_q == STEP_W'(DIV_BITS-1), "divider load")

endmodule

@@ rtl/pwm_input_capture_measure.sv @@
// PWM input capture: measures period, frequency and duty of a sampled pin.
// s_axis: one beat per tick. tuser = func (1 starts a measurement, clears
//   the counter and arms capture; 0 is a tick), tdata[0] = pin level.
// cfg: write cfg_data_i (counter tick rate in Hz) with cfg_valid_i; always
//   ready. Write only while no measurement result is outstanding.
// m_axis: one beat per completed capture sequence. tuser = valid_res,
//   tdata = period[15:0], frequency[41:16], duty Q8 percent[56:42].
// Input accepts one beat per cycle unless the queue is full; capture runs in the
//   front end; the three capture values pass via a two-entry queue to the back end.
// The beat holding the second rising edge pushes the capture into the queue;
//   the back end pops it, loads operands and runs 31-step shared-counter dividers.
// The back end works on one result at a time and pops only while idle;
//   s_axis_tready drops only while the queue is full, which needs back-to-back short measurements
//   or a stalled m_axis.
// A stalled m_axis holds the result; the front end keeps sampling until the
//   queue fills.
// Reset: idle, counter 0, previous level 1, tick rate 8000000 Hz.
module pwm_input_capture_measure
  import pimc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CLK_W-1:0]      cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [0] signal_level
  input  logic                  s_axis_tuser,  // [0] func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // period_ticks, frequency_hz, duty_q8
  output logic                  m_axis_tuser   // [0] valid_res
);

  logic  push, full, pop, empty;
  capt_t capt_w, capt_r;

  pimc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser),
    .level_i    (s_axis_tdata[0]),
    .push_o     (push),
    .capt_o     (capt_w),
    .full_i     (full)
  );

  pimc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (capt_w),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (capt_r),
    .empty_o (empty)
  );

  pimc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .empty_i     (empty),
    .capt_i      (capt_r),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .valid_res_o (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import pimc_pkg::*;

  localparam logic FN_TICK  = 1'b0;
  localparam logic FN_START = 1'b1;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned PHASE_ITEMS   = 185;
  localparam logic [CLK_W-1:0] RATE_TOP  = CLK_W'(100000000);
  localparam logic [CLK_W-1:0] RATE_MIN  = CLK_W'(1);
  localparam logic [CLK_W-1:0] RATE_OVER = {CLK_W{1'b1}};

  typedef enum logic [1:0] {ST_IDLE, ST_RISE1, ST_FALL, ST_RISE2} cap_stage_e;

  typedef struct {
    logic        fn;
    logic        lvl;
    int unsigned gap;
  } stim_t;

  typedef struct packed {
    logic              ok;
    logic [PER_W-1:0]  period;
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
  } meas_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CLK_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;  // [0] signal_level
  logic                  s_axis_tuser = 1'b0;  // [0] func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;  // [15:0] period, [41:16] freq, [56:42] duty
  logic                  m_axis_tuser;  // [0] valid_res

  pwm_input_capture_measure dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // capture tracker state
  cap_stage_e            cap_stage = ST_IDLE;
  logic [COUNT_BITS-1:0] tick_cnt  = '0;
  logic                  pin_prev  = 1'b1;
  logic [COUNT_BITS-1:0] cap_rise1 = '0;
  logic [COUNT_BITS-1:0] cap_fall  = '0;
  logic [COUNT_BITS-1:0] cap_rise2 = '0;
  logic [CLK_W-1:0]      rate_hz   = CLOCK_RESET;

  stim_t       stim_q[$];
  meas_t       pending_meas[$];
  int unsigned n_queued  = 0;
  int unsigned n_beats   = 0;
  int unsigned n_results = 0;
  int unsigned n_invalid = 0;
  int unsigned n_writes  = 0;
  int unsigned errors    = 0;
  int unsigned cycles    = 0;
  int unsigned tx_wait   = 0;
  int unsigned rx_wait   = 0;
  logic        in_fire   = 1'b0;
  logic        out_fire  = 1'b0;
  logic        cfg_fire  = 1'b0;
  logic        rx_hold   = 1'b0;
  bit          hold_go   = 1'b0;

  function automatic meas_t measure_of(input logic [COUNT_BITS-1:0] a, b, c,
                                       input logic [CLK_W-1:0] hz);
    meas_t                 r;
    logic [COUNT_BITS-1:0] per;
    logic [COUNT_BITS-1:0] hi;
    logic [31:0]           f;
    logic [31:0]           d;
    r = '0;
    if (a < b && b < c) begin
      per = c - a;
      hi = b - a;
      f = 32'(hz) / 32'(per);
      d = (32'(hi) * 32'(DUTY_SCALE)) / 32'(per);
      r.ok = 1'b1;
      r.period = per[PER_W-1:0];
      r.freq = (f > 32'(FREQ_MAX)) ? FREQ_MAX : f[FREQ_W-1:0];
      r.duty = d[DUTY_W-1:0];
    end
    return r;
  endfunction

  function automatic void track_pin(input logic fn, input logic lvl);
    logic rise;
    logic fall;
    rise = !pin_prev && lvl;
    fall = pin_prev && !lvl;
    if (fn == FN_START) begin
      tick_cnt = '0;
      cap_stage = ST_RISE1;
      return;
    end
    pin_prev = lvl;
    if (cap_stage == ST_IDLE) return;
    if (cap_stage == ST_RISE1 && rise) begin
      cap_rise1 = tick_cnt;
      cap_stage = ST_FALL;
    end else if (cap_stage == ST_FALL && fall) begin
      cap_fall = tick_cnt;
      cap_stage = ST_RISE2;
    end else if (cap_stage == ST_RISE2 && rise) begin
      cap_rise2 = tick_cnt;
      cap_stage = ST_IDLE;
      pending_meas.push_back(measure_of(cap_rise1, cap_fall, cap_rise2, rate_hz));
    end
    if (cap_stage != ST_IDLE) tick_cnt = tick_cnt + COUNT_BITS'(1);
  endfunction

  task automatic report(input string what, input meas_t want, input meas_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t %s: exp ok=%0d per=%0d freq=%0d duty=%0d, got ok=%0d per=%0d freq=%0d duty=%0d",
               $realtime, what, want.ok, want.period, want.freq, want.duty,
               got.ok, got.period, got.freq, got.duty);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // sample handshakes, predict and score
  always @(posedge clk_i) begin : score
    meas_t got;
    meas_t want;
    in_fire  <= s_axis_tvalid && s_axis_tready;
    out_fire <= m_axis_tvalid && m_axis_tready;
    cfg_fire <= cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        rate_hz = cfg_data_i;
        n_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        track_pin(s_axis_tuser, s_axis_tdata[0]);
        n_beats++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.ok     = m_axis_tuser;
        got.period = m_axis_tdata[15:0];
        got.freq   = m_axis_tdata[41:16];
        got.duty   = m_axis_tdata[56:42];
        n_results++;
        if (pending_meas.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = pending_meas.pop_front();
          if (!want.ok) n_invalid++;
          if (got.ok !== want.ok || got.period !== want.period ||
              got.freq !== want.freq || got.duty !== want.duty) begin
            report("result mismatch", want, got);
          end
        end
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin : drive_in
    stim_t nxt;
    if (!s_axis_tvalid || in_fire) begin
      if (stim_q.size() != 0 && tx_wait >= stim_q[0].gap) begin
        nxt = stim_q.pop_front();
        s_axis_tuser  <= nxt.fn;
        s_axis_tdata  <= {7'd0, nxt.lvl};
        s_axis_tvalid <= 1'b1;
        tx_wait = 0;
      end else begin
        s_axis_tvalid <= 1'b0;
        if (stim_q.size() != 0) tx_wait++;
      end
    end
  end

  // output receiver
  always @(negedge clk_i) begin
    if (out_fire) rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (!rst_ni || rx_hold || rx_wait != 0) begin
      m_axis_tready <= 1'b0;
      if (rx_wait != 0) rx_wait--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // long receiver stall so the capture queue fills
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 5);
  endfunction

  task automatic push(input logic fn, input logic lvl, input bit dense);
    stim_t s;
    s.fn  = fn;
    s.lvl = lvl;
    s.gap = dense ? 0 : pick_gap();
    stim_q.push_back(s);
    n_queued++;
  endtask

  task automatic add_ticks(input logic lvl, input int unsigned n, input bit dense);
    repeat (n) push(FN_TICK, lvl, dense);
  endtask

  task automatic add_meas(input bit dense);
    push(FN_START, 1'($urandom_range(0, 1)), dense);
    repeat ($urandom_range(0, 3)) push(FN_TICK, 1'($urandom_range(0, 1)), dense);
    add_ticks(1'b0, pick_len(), dense);
    add_ticks(1'b1, pick_len(), dense);
    add_ticks(1'b0, pick_len(), dense);
    add_ticks(1'b1, 1, dense);
  endtask

  // short period-2 capture: rise at 0, fall at 1, rise at 2
  task automatic add_short();
    push(FN_TICK, 1'b0, 1'b0);
    push(FN_START, 1'b1, 1'b0);
    push(FN_TICK, 1'b1, 1'b0);
    push(FN_TICK, 1'b0, 1'b0);
    push(FN_TICK, 1'b1, 1'b0);
  endtask

  task automatic fill_random(input int unsigned n_items, input bit force_dense);
    int unsigned goal;
    bit          dense;
    goal = n_queued + n_items;
    while (n_queued < goal) begin
      dense = force_dense || ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        7: repeat ($urandom_range(1, 8)) push(FN_TICK, 1'($urandom_range(0, 1)), dense);
        8: begin
          push(FN_START, 1'($urandom_range(0, 1)), dense);
          repeat ($urandom_range(0, 6)) push(FN_TICK, 1'($urandom_range(0, 1)), dense);
        end
        9: push(FN_START, 1'($urandom_range(0, 1)), dense);
        default: add_meas(dense);
      endcase
    end
  endtask

  task automatic drain(input int unsigned settle);
    while (stim_q.size() != 0 || s_axis_tvalid || pending_meas.size() != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_rate(input logic [CLK_W-1:0] hz);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= hz;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CLK_W-1:0] rates [6];
    rates[0] = CLK_W'($urandom_range(2, 99999999));
    rates[1] = RATE_MIN;
    rates[2] = RATE_TOP;
    rates[3] = RATE_OVER;
    rates[4] = CLK_W'($urandom_range(2, 99999999));
    rates[5] = CLOCK_RESET;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // idle ticks are ignored, then a minimal capture at the reset rate
    push(FN_TICK, 1'b0, 1'b0);
    push(FN_TICK, 1'b1, 1'b0);
    push(FN_START, 1'b0, 1'b0);
    add_ticks(1'b0, 1, 1'b0);
    add_ticks(1'b1, 1, 1'b0);
    add_ticks(1'b0, 1, 1'b0);
    add_ticks(1'b1, 1, 1'b0);
    // restart in mid capture keeps the pin history
    push(FN_START, 1'b1, 1'b0);
    add_ticks(1'b0, 1, 1'b0);
    add_ticks(1'b1, 1, 1'b0);
    push(FN_START, 1'b0, 1'b0);
    add_ticks(1'b0, 1, 1'b0);
    add_ticks(1'b1, 3, 1'b0);
    add_ticks(1'b0, 2, 1'b0);
    add_ticks(1'b1, 1, 1'b0);
    drain(SETTLE_CYCLES);

    // top rate, shortest period
    write_rate(RATE_TOP);
    add_short();
    drain(SETTLE_CYCLES);

    // largest rate, shortest period: the frequency reaches FREQ_MAX
    write_rate(RATE_OVER);
    add_short();
    drain(SETTLE_CYCLES);

    // rate of 1 Hz
    write_rate(RATE_MIN);
    add_short();
    drain(SETTLE_CYCLES);

    for (int p = 0; p < 6; p++) begin
      write_rate(rates[p]);
      if (p == 2) hold_go = 1'b1;
      fill_random(PHASE_ITEMS, p == 2);
      drain(SETTLE_CYCLES);
    end

    drain(2 * SETTLE_CYCLES);
    $display("run: %0d input beats, %0d results (%0d invalid), %0d rate writes",
             n_beats, n_results, n_invalid, n_writes);
    $display("included idle ticks, restarts, rate extremes with saturation and a long output stall");
    if (pending_meas.size() != 0) begin
      $display("%0d results never arrived", pending_meas.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
